>>> rtl/core/lhp_pkg.sv
// ----------------------------------------------------------------------------
// lhp_pkg
// Shared types and constants for the length-prefixed name header parser.
// ----------------------------------------------------------------------------
package lhp_pkg;

    // Default total header budget; names may use up to this minus four bytes
    localparam int MAX_HEADER_DEF = 256;

    // Parser phase
    typedef enum logic [2:0] {
        PH_SRC_LEN  = 3'd0,
        PH_SRC_NAME = 3'd1,
        PH_DST_LEN  = 3'd2,
        PH_DST_NAME = 3'd3,
        PH_DONE     = 3'd4,
        PH_ERROR    = 3'd5
    } t_phase;

    // Result status codes
    localparam logic [1:0] ST_NEED  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Region codes
    localparam logic [1:0] RG_SRC_LEN  = 2'd0;
    localparam logic [1:0] RG_SRC_NAME = 2'd1;
    localparam logic [1:0] RG_DST_LEN  = 2'd2;
    localparam logic [1:0] RG_DST_NAME = 2'd3;

    // Request action on the input side
    localparam logic ACT_DATA  = 1'b0;
    localparam logic ACT_START = 1'b1;

    // Packed result width before byte padding, and padded width
    localparam int RES_W  = 29;
    localparam int TDATA_W = 32;

    // One result request
    typedef struct packed {
        logic [7:0] dest_length;
        logic [7:0] source_length;
        logic [7:0] byte_offset;
        logic [1:0] region;
        logic       consumed;
        logic [1:0] status;
    } t_result;

endpackage

>>> rtl/core/length_prefixed_name_header_parser_unit.sv
// ----------------------------------------------------------------------------
// length_prefixed_name_header_parser_unit
// Parses a header of two length-prefixed names, one byte per request, and
// writes the name bytes into two on-chip name stores.
// ----------------------------------------------------------------------------
// An accepted request's result is registered in the output register, or in
// the skid entry while the output holds an untaken result. One byte is taken
// per cycle while the skid entry is empty; phase and length feed the next byte.
// A two-entry output buffer keeps input accepted while one result waits.
// Reset (synchronous, active low) returns the parser to the source length
// phase and empties the output buffer; name store contents are not cleared.
// ----------------------------------------------------------------------------
module length_prefixed_name_header_parser_unit #(
    parameter int MAX_HEADER = lhp_pkg::MAX_HEADER_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic [0:0]  i_s_tuser,   // [0] action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [1:0] status, [2] consumed, [4:3] region, [12:5] byte_offset,
    // [20:13] source_length, [28:21] dest_length, [31:29] zero
    output logic [31:0] o_m_tdata
);

    localparam int          NAME_DEPTH = MAX_HEADER - 4;
    localparam int          PW         = $clog2(MAX_HEADER);
    localparam int          AW         = $clog2(NAME_DEPTH);
    localparam logic [31:0] NAME_LIMIT = 32'(MAX_HEADER - 4);

    // Parser state
    lhp_pkg::t_phase r_phase, n_phase;
    logic [PW-1:0]   r_count, n_count;
    logic [31:0]     r_src_acc, n_src_acc;
    logic [31:0]     r_dst_acc, n_dst_acc;

    // Output buffer
    logic [31:0] r_out_data;
    logic        r_out_valid;
    logic [31:0] r_skid_data;
    logic        r_skid_valid;

    logic            in_acc;
    logic            out_take;
    lhp_pkg::t_result res;
    logic [31:0]     res_word;
    logic [PW-1:0]   cnt_inc;
    logic            src_ok;
    logic            dst_ok;
    logic            src_we;
    logic            dst_we;
    logic            addr_ok;

    assign o_s_tready = !r_skid_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_take   = r_out_valid && i_m_tready;
    assign cnt_inc    = r_count + 1'b1;
    assign addr_ok    = (r_count < PW'(NAME_DEPTH));

    // Hold parser state; advance on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= lhp_pkg::PH_SRC_LEN;
            r_count   <= '0;
            r_src_acc <= '0;
            r_dst_acc <= '0;
        end else if (in_acc) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_src_acc <= n_src_acc;
            r_dst_acc <= n_dst_acc;
        end
    end

    // Next phase, length accumulation and result fields
    always_comb begin
        n_phase        = r_phase;
        n_count        = r_count;
        n_src_acc      = r_src_acc;
        n_dst_acc      = r_dst_acc;
        src_we         = 1'b0;
        dst_we         = 1'b0;
        res.status     = lhp_pkg::ST_NEED;
        res.consumed   = 1'b1;
        res.region     = lhp_pkg::RG_SRC_LEN;
        res.byte_offset = 8'(r_count);

        if (i_s_tuser[0] == lhp_pkg::ACT_START) begin
            n_phase         = lhp_pkg::PH_SRC_LEN;
            n_count         = '0;
            n_src_acc       = '0;
            n_dst_acc       = '0;
            res.consumed    = 1'b0;
            res.byte_offset = '0;
        end else begin
            unique case (r_phase)
                lhp_pkg::PH_SRC_LEN: begin
                    n_src_acc = {r_src_acc[23:0], i_s_tdata};
                    n_count   = cnt_inc;
                    if (r_count == PW'(3)) begin
                        n_count = '0;
                        if (n_src_acc > NAME_LIMIT) begin
                            n_phase    = lhp_pkg::PH_ERROR;
                            res.status = lhp_pkg::ST_ERROR;
                        end else if (n_src_acc == '0) begin
                            n_phase = lhp_pkg::PH_DST_LEN;
                        end else begin
                            n_phase = lhp_pkg::PH_SRC_NAME;
                        end
                    end
                end
                lhp_pkg::PH_SRC_NAME: begin
                    src_we     = addr_ok;
                    res.region = lhp_pkg::RG_SRC_NAME;
                    n_count    = cnt_inc;
                    if (cnt_inc == r_src_acc[PW-1:0]) begin
                        n_count = '0;
                        n_phase = lhp_pkg::PH_DST_LEN;
                    end
                end
                lhp_pkg::PH_DST_LEN: begin
                    res.region = lhp_pkg::RG_DST_LEN;
                    n_dst_acc  = {r_dst_acc[23:0], i_s_tdata};
                    n_count    = cnt_inc;
                    if (r_count == PW'(3)) begin
                        n_count = '0;
                        if (n_dst_acc > NAME_LIMIT) begin
                            n_phase    = lhp_pkg::PH_ERROR;
                            res.status = lhp_pkg::ST_ERROR;
                        end else if (n_dst_acc == '0) begin
                            n_phase    = lhp_pkg::PH_DONE;
                            res.status = lhp_pkg::ST_DONE;
                        end else begin
                            n_phase = lhp_pkg::PH_DST_NAME;
                        end
                    end
                end
                lhp_pkg::PH_DST_NAME: begin
                    dst_we     = addr_ok;
                    res.region = lhp_pkg::RG_DST_NAME;
                    n_count    = cnt_inc;
                    if (cnt_inc == r_dst_acc[PW-1:0]) begin
                        n_count    = '0;
                        n_phase    = lhp_pkg::PH_DONE;
                        res.status = lhp_pkg::ST_DONE;
                    end
                end
                lhp_pkg::PH_DONE: begin
                    res.status      = lhp_pkg::ST_DONE;
                    res.consumed    = 1'b0;
                    res.region      = lhp_pkg::RG_DST_NAME;
                    res.byte_offset = '0;
                end
                default: begin
                    n_phase         = lhp_pkg::PH_ERROR;
                    res.status      = lhp_pkg::ST_ERROR;
                    res.consumed    = 1'b0;
                    res.byte_offset = '0;
                end
            endcase
        end

        // Report lengths only once decoded and within the limit
        src_ok = (n_phase == lhp_pkg::PH_SRC_NAME) || (n_phase == lhp_pkg::PH_DST_LEN) ||
                 (n_phase == lhp_pkg::PH_DST_NAME) || (n_phase == lhp_pkg::PH_DONE) ||
                 ((n_phase == lhp_pkg::PH_ERROR) && (n_src_acc <= NAME_LIMIT));
        dst_ok = (n_phase == lhp_pkg::PH_DST_NAME) || (n_phase == lhp_pkg::PH_DONE);
        res.source_length = src_ok ? n_src_acc[7:0] : 8'd0;
        res.dest_length   = dst_ok ? n_dst_acc[7:0] : 8'd0;
    end

    assign res_word = {{(lhp_pkg::TDATA_W - lhp_pkg::RES_W){1'b0}}, res};

    // Output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Steer result payload into the output or skid entry
    always_ff @(posedge i_clk) begin
        if (out_take) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else begin
                r_out_data <= res_word;
            end
        end else if (in_acc) begin
            if (r_out_valid) begin
                r_skid_data <= res_word;
            end else begin
                r_out_data <= res_word;
            end
        end
    end

    // Name stores
    lhp_name_store #(
        .DEPTH (NAME_DEPTH),
        .AW    (AW)
    ) u_src_store (
        .i_clk  (i_clk),
        .i_we   (in_acc && src_we),
        .i_addr (r_count[AW-1:0]),
        .i_data (i_s_tdata)
    );

    lhp_name_store #(
        .DEPTH (NAME_DEPTH),
        .AW    (AW)
    ) u_dst_store (
        .i_clk  (i_clk),
        .i_we   (in_acc && dst_we),
        .i_addr (r_count[AW-1:0]),
        .i_data (i_s_tdata)
    );

endmodule

>>> rtl/core/lhp_name_store.sv
// ----------------------------------------------------------------------------
// lhp_name_store
// Single-port synchronous name store, one byte wide, written by the parser.
// ----------------------------------------------------------------------------
module lhp_name_store #(
    parameter int DEPTH = lhp_pkg::MAX_HEADER_DEF - 4,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_data
);

    logic [7:0] r_mem [DEPTH];

    // Store one name byte
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_data;
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the length-prefixed name header parser. Requests
// are driven on the slave-side stream, each accepted request is run through a
// local parser model, and every result on the master-side stream is compared
// field by field with the oldest pending prediction. Directed headers cover
// start actions, zero lengths, oversized lengths and bytes after completion
// or error. Random headers then run under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;
    import lhp_pkg::*;

    localparam logic [31:0] NAME_LIMIT  = MAX_HEADER_DEF - 4;
    localparam int          STALL_LIMIT = 2000;
    localparam int          DRAIN_CYCLES = 4;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'h00;   // [7:0] data_byte
    logic [0:0]  i_s_tuser  = 1'b0;    // [0] action
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // [1:0] status, [2] consumed, [4:3] region, [12:5] byte_offset,
    // [20:13] source_length, [28:21] dest_length, [31:29] zero
    logic [31:0] o_m_tdata;

    // Parser model state; the name stores are write-only in the block and
    // never shape a result, so they are not kept here
    t_phase      hdr_phase   = PH_SRC_LEN;
    logic [7:0]  hdr_pos     = 8'd0;
    logic [31:0] src_len_acc = 32'd0;
    logic [31:0] dst_len_acc = 32'd0;

    t_result     pending_results[$];
    t_result     want_res;
    t_result     got_res;
    int          n_fail        = 0;
    int          n_sent        = 0;
    int          idle_cycles   = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    length_prefixed_name_header_parser_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the parser model by one request and build its result
    function automatic t_result predict_parse(logic act, logic [7:0] b);
        t_result    r;
        logic [1:0] st;
        logic       used;
        logic [1:0] rg;
        logic [7:0] off;
        logic       src_ok;
        logic       dst_ok;
        st   = ST_NEED;
        used = 1'b1;
        rg   = RG_SRC_LEN;
        off  = hdr_pos;
        if (act == ACT_START) begin
            hdr_phase   = PH_SRC_LEN;
            hdr_pos     = 8'd0;
            src_len_acc = 32'd0;
            dst_len_acc = 32'd0;
            used        = 1'b0;
            off         = 8'd0;
        end else begin
            case (hdr_phase)
                PH_SRC_LEN: begin
                    src_len_acc = {src_len_acc[23:0], b};
                    hdr_pos     = hdr_pos + 8'd1;
                    if (hdr_pos >= 8'd4) begin
                        hdr_pos = 8'd0;
                        if (src_len_acc > NAME_LIMIT) begin
                            hdr_phase = PH_ERROR;
                            st        = ST_ERROR;
                        end else begin
                            hdr_phase = (src_len_acc == 32'd0) ? PH_DST_LEN : PH_SRC_NAME;
                        end
                    end
                end
                PH_SRC_NAME: begin
                    rg      = RG_SRC_NAME;
                    hdr_pos = hdr_pos + 8'd1;
                    if (32'(hdr_pos) >= src_len_acc) begin
                        hdr_pos   = 8'd0;
                        hdr_phase = PH_DST_LEN;
                    end
                end
                PH_DST_LEN: begin
                    rg          = RG_DST_LEN;
                    dst_len_acc = {dst_len_acc[23:0], b};
                    hdr_pos     = hdr_pos + 8'd1;
                    if (hdr_pos >= 8'd4) begin
                        hdr_pos = 8'd0;
                        if (dst_len_acc > NAME_LIMIT) begin
                            hdr_phase = PH_ERROR;
                            st        = ST_ERROR;
                        end else if (dst_len_acc == 32'd0) begin
                            hdr_phase = PH_DONE;
                            st        = ST_DONE;
                        end else begin
                            hdr_phase = PH_DST_NAME;
                        end
                    end
                end
                PH_DST_NAME: begin
                    rg      = RG_DST_NAME;
                    hdr_pos = hdr_pos + 8'd1;
                    if (32'(hdr_pos) >= dst_len_acc) begin
                        hdr_pos   = 8'd0;
                        hdr_phase = PH_DONE;
                        st        = ST_DONE;
                    end
                end
                PH_DONE: begin
                    st   = ST_DONE;
                    used = 1'b0;
                    rg   = RG_DST_NAME;
                    off  = 8'd0;
                end
                default: begin
                    hdr_phase = PH_ERROR;
                    st        = ST_ERROR;
                    used      = 1'b0;
                    off       = 8'd0;
                end
            endcase
        end
        // Lengths show only once decoded and within the limit
        src_ok = (hdr_phase >= PH_SRC_NAME && hdr_phase <= PH_DONE) ||
                 (hdr_phase == PH_ERROR && src_len_acc <= NAME_LIMIT);
        dst_ok = (hdr_phase == PH_DST_NAME || hdr_phase == PH_DONE);
        r.status        = st;
        r.consumed      = used;
        r.region        = rg;
        r.byte_offset   = off;
        r.source_length = src_ok ? src_len_acc[7:0] : 8'd0;
        r.dest_length   = dst_ok ? dst_len_acc[7:0] : 8'd0;
        return r;
    endfunction

    // Send one request, idling first at the current rate, then predict it
    task automatic send_request(logic act, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_results.push_back(predict_parse(act, b));
        n_sent++;
    endtask

    // Send a 4-byte big-endian length
    task automatic send_length(logic [31:0] len);
        for (int i = 3; i >= 0; i--) send_request(ACT_DATA, len[8*i +: 8]);
    endtask

    task automatic send_name(int unsigned len);
        repeat (len) send_request(ACT_DATA, 8'($urandom));
    endtask

    task automatic send_header(logic [31:0] src_len, logic [31:0] dst_len);
        send_length(src_len);
        send_name(src_len);
        send_length(dst_len);
        send_name(dst_len);
    endtask

    // Mostly short names, a few empty ones
    function automatic logic [31:0] pick_name_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) return 32'd0;
        if (r < 85) return $urandom_range(1, 6);
        return $urandom_range(7, 24);
    endfunction

    // Just over the limit, or far over it with the top byte set
    function automatic logic [31:0] pick_oversize();
        if ($urandom_range(1) == 0) return $urandom_range(NAME_LIMIT + 1, 260);
        return $urandom | 32'h0100_0000;
    endfunction

    // Start action ignores its data byte and clears everything
    task automatic test_start_action();
        send_request(ACT_START, 8'hA5);
        send_request(ACT_START, 8'hFF);
    endtask

    // One-byte source name, empty destination completes on its last
    // length byte, then a byte after completion
    task automatic test_zero_dest_and_trailing();
        send_request(ACT_START, 8'h00);
        send_length(32'd1);
        send_request(ACT_DATA, 8'hFF);
        send_length(32'd0);
        send_request(ACT_DATA, 8'h00);
    endtask

    // Oversized source length, then a byte in the error phase
    task automatic test_source_length_error();
        send_request(ACT_START, 8'h3C);
        send_length(32'hFFFF_FFFF);
        send_request(ACT_DATA, 8'h5A);
    endtask

    // Empty source name skipped, destination length one over the limit
    task automatic test_dest_length_error();
        send_request(ACT_START, 8'h00);
        send_length(32'd0);
        send_length(NAME_LIMIT + 1);
        send_request(ACT_DATA, 8'hC3);
    endtask

    // Both names at the largest allowed length
    task automatic test_longest_names();
        send_request(ACT_START, 8'h00);
        send_header(NAME_LIMIT, NAME_LIMIT);
        send_request(ACT_DATA, 8'($urandom));
    endtask

    // Mostly well-formed headers, some with oversized lengths, some noise
    task automatic test_random_headers(int n_items);
        int          stop_at;
        int unsigned mode;
        logic [31:0] src_len;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at) begin
            mode = $urandom_range(99);
            send_request(ACT_START, 8'($urandom));
            if (mode < 75) begin
                send_header(pick_name_length(), pick_name_length());
            end else if (mode < 88) begin
                if ($urandom_range(1) == 0) begin
                    send_length(pick_oversize());
                end else begin
                    src_len = pick_name_length();
                    send_length(src_len);
                    send_name(src_len);
                    send_length(pick_oversize());
                end
            end else begin
                repeat ($urandom_range(1, 12))
                    send_request(($urandom_range(9) == 0) ? ACT_START : ACT_DATA,
                                 8'($urandom));
            end
            repeat ($urandom_range(0, 2)) send_request(ACT_DATA, 8'($urandom));
        end
    endtask

    // Stall the result side at the current rate
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic check_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", fname, want, got);
            n_fail++;
        end
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_res = t_result'(o_m_tdata[RES_W-1:0]);
            if (pending_results.size() == 0) begin
                $error("result with no request pending: tdata %h", o_m_tdata);
                n_fail++;
            end else begin
                want_res = pending_results.pop_front();
                check_field("status", want_res.status, got_res.status);
                check_field("consumed", want_res.consumed, got_res.consumed);
                check_field("region", want_res.region, got_res.region);
                check_field("byte_offset", want_res.byte_offset, got_res.byte_offset);
                check_field("source_length", want_res.source_length,
                            got_res.source_length);
                check_field("dest_length", want_res.dest_length, got_res.dest_length);
                check_field("pad", 0, o_m_tdata[TDATA_W-1:RES_W]);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_start_action();
        test_zero_dest_and_trailing();
        test_source_length_error();
        test_dest_length_error();
        test_random_headers(180);

        send_idle_pct = 71;
        test_random_headers(180);

        send_idle_pct  = 0;
        recv_stall_pct = 71;
        test_random_headers(180);

        send_idle_pct  = 25;
        recv_stall_pct = 25;
        test_longest_names();
        test_random_headers(180);

        // Drain remaining results
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
